// File: sv/e2e_checked_can_frame_decoder_defines.svh
// ----------------------------------------------------------------------------
// E2E CAN frame decoder assertion macros
// Shared concurrent assertion shorthands for the decoder RTL.
// ----------------------------------------------------------------------------
`ifndef E2E_CHECKED_CAN_FRAME_DECODER_DEFINES_SVH
`define E2E_CHECKED_CAN_FRAME_DECODER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define E2ECAN_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define E2ECAN_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/e2ecan_pkg.sv
// ----------------------------------------------------------------------------
// E2E CAN decoder package
// Field widths, status codes and the CRC-8 (poly 0x2F) byte update.
// ----------------------------------------------------------------------------
package e2ecan_pkg;

    localparam int PAYLOAD_W   = 64;
    localparam int LEN_W       = 4;
    localparam int STATUS_W    = 2;
    localparam int CHECK_W     = 8;
    localparam int SEQ_W       = 4;
    localparam int SPEED_W     = 8;
    localparam int RPM_W       = 14;
    localparam int COOLANT_W   = 9;
    localparam int DATA_ID_W   = 16;
    localparam int NUM_CRC_BYTES = 7;

    localparam logic [7:0]       CRC_POLY       = 8'h2F;
    localparam logic [7:0]       CRC_INIT       = 8'hFF;
    localparam logic [7:0]       CRC_XOROUT     = 8'hFF;
    localparam logic [LEN_W-1:0] FULL_FRAME     = 4'd8;
    localparam logic [8:0]       COOLANT_OFFSET = 9'd40;

    typedef enum logic [STATUS_W-1:0] {
        ST_ACCEPTED = 2'd0,
        ST_SHORT    = 2'd1,
        ST_CRC_ERR  = 2'd2,
        ST_CNT_ERR  = 2'd3
    } status_t;

    // One byte through the MSB-first CRC-8 shift register.
    function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int b = 0; b < 8; b++) begin
            if (c[7])
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

    // CRC state after the data ID, low byte first.
    function automatic logic [7:0] crc8_seed(input logic [DATA_ID_W-1:0] id);
        return crc8_feed(crc8_feed(CRC_INIT, id[7:0]), id[15:8]);
    endfunction

    localparam logic [7:0] SEED_RESET = crc8_seed(16'h0000);

endpackage

// File: sv/e2ecan_if.sv
// ----------------------------------------------------------------------------
// E2E CAN decoder channels
// Valid/ready interfaces for the frame input and the decoded result output.
// ----------------------------------------------------------------------------
interface e2ecan_in_if;
    import e2ecan_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [PAYLOAD_W-1:0] payload;
    logic [LEN_W-1:0]     frame_length;

    modport source (output valid, output payload, output frame_length, input ready);
    modport sink   (input valid, input payload, input frame_length, output ready);
endinterface

interface e2ecan_out_if;
    import e2ecan_pkg::*;

    logic                        valid;
    logic                        ready;
    logic [STATUS_W-1:0]         status;
    logic [CHECK_W-1:0]          received_check;
    logic [CHECK_W-1:0]          computed_check;
    logic [SEQ_W-1:0]            sequence_count;
    logic [SPEED_W-1:0]          speed;
    logic [RPM_W-1:0]            engine_speed;
    logic signed [COOLANT_W-1:0] coolant;

    modport source (output valid, output status, output received_check,
                    output computed_check, output sequence_count, output speed,
                    output engine_speed, output coolant, input ready);
    modport sink   (input valid, input status, input received_check,
                    input computed_check, input sequence_count, input speed,
                    input engine_speed, input coolant, output ready);
endinterface

// File: sv/e2ecan_crc.sv
// ----------------------------------------------------------------------------
// E2E CAN CRC-8 network
// Folds frame bytes 1 to 7 into a preloaded seed and applies the final XOR.
// ----------------------------------------------------------------------------
module e2ecan_crc (
    input  logic [7:0]  seed,
    input  logic [55:0] data,
    output logic [7:0]  crc
);
    import e2ecan_pkg::*;

    always_comb
    begin
        logic [7:0] c;
        c = seed;
        for (int i = 0; i < NUM_CRC_BYTES; i++) begin
            c = crc8_feed(c, data[8*i +: 8]);
        end
        crc = c ^ CRC_XOROUT;
    end

endmodule

// File: sv/e2e_checked_can_frame_decoder.sv
// A frame passes through the input register (s1) and then the result register.
// Throughput: one frame per cycle while the result side is not stalled; the CRC, counter check and field decode
// sit in one combinational stage between the input register and the result register.
// Reset (rst_n low, asynchronous) clears the pipeline valids, the rolling
// counter state and loads the CRC seed for data ID 0.
// ----------------------------------------------------------------------------
// E2E-checked CAN frame decoder
// CRC-8 and rolling counter check of an eight-byte frame, then signal decode.
// ----------------------------------------------------------------------------
`include "e2e_checked_can_frame_decoder_defines.svh"

module e2e_checked_can_frame_decoder (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              data_id_we,
    input  logic [e2ecan_pkg::DATA_ID_W-1:0] data_id_wdata,
    e2ecan_in_if.sink                         frame,
    e2ecan_out_if.source                      result
);
    import e2ecan_pkg::*;

    // CRC state after the data ID, refreshed on each register write
    logic [7:0] seed_reg;

    logic                 s1_valid_reg;
    logic [PAYLOAD_W-1:0] s1_payload_reg;
    logic [LEN_W-1:0]     s1_len_reg;

    logic             have_prev_reg, have_prev_next;
    logic [SEQ_W-1:0] prev_count_reg, prev_count_next;

    logic                        out_valid_reg;
    status_t                     status_reg, status_next;
    logic [CHECK_W-1:0]          rx_reg, rx_next;
    logic [CHECK_W-1:0]          crc_reg, crc_next;
    logic [SEQ_W-1:0]            seq_reg, seq_next;
    logic [SPEED_W-1:0]          speed_reg, speed_next;
    logic [RPM_W-1:0]            rpm_reg, rpm_next;
    logic signed [COOLANT_W-1:0] coolant_reg, coolant_next;

    logic             s2_load;
    logic             s1_adv;
    logic             s1_short;
    logic             crc_bad;
    logic             cnt_bad;
    logic             s1_accept;
    logic [7:0]       crc_calc;
    logic [7:0]       byte0;
    logic [SEQ_W-1:0] cnt;
    logic [15:0]      rpm_raw;

    e2ecan_crc u_crc (
        .seed (seed_reg),
        .data (s1_payload_reg[63:8]),
        .crc  (crc_calc)
    );

    assign s2_load     = !out_valid_reg || result.ready;
    assign s1_adv      = s1_valid_reg && s2_load;
    assign frame.ready = !s1_valid_reg || s2_load;

    assign byte0     = s1_payload_reg[7:0];
    assign cnt       = s1_payload_reg[11:8];
    assign rpm_raw   = s1_payload_reg[39:24];
    assign s1_short  = s1_len_reg < FULL_FRAME;
    assign crc_bad   = byte0 != crc_calc;
    assign cnt_bad   = have_prev_reg && (cnt != prev_count_reg + SEQ_W'(1));
    assign s1_accept = !s1_short && !crc_bad && !cnt_bad;

    always_comb
    begin
        status_next  = ST_ACCEPTED;
        rx_next      = byte0;
        crc_next     = crc_calc;
        seq_next     = cnt;
        speed_next   = '0;
        rpm_next     = '0;
        coolant_next = '0;
        if (s1_short) begin
            status_next = ST_SHORT;
            rx_next     = '0;
            crc_next    = '0;
            seq_next    = '0;
        end else if (crc_bad) begin
            status_next = ST_CRC_ERR;
        end else if (cnt_bad) begin
            status_next = ST_CNT_ERR;
        end else begin
            speed_next   = s1_payload_reg[23:16];
            rpm_next     = rpm_raw[15:2];
            coolant_next = $signed({1'b0, s1_payload_reg[47:40]} - COOLANT_OFFSET);
        end
    end

    always_comb
    begin
        have_prev_next  = have_prev_reg;
        prev_count_next = prev_count_reg;
        // advance the rolling counter only when the frame passes every check
        if (s1_adv && s1_accept) begin
            have_prev_next  = 1'b1;
            prev_count_next = cnt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            seed_reg       <= SEED_RESET;
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            have_prev_reg  <= 1'b0;
            prev_count_reg <= '0;
        end else begin
            if (data_id_we)
                seed_reg <= crc8_seed(data_id_wdata);
            if (frame.ready)
                s1_valid_reg <= frame.valid;
            if (s2_load)
                out_valid_reg <= s1_valid_reg;
            have_prev_reg  <= have_prev_next;
            prev_count_reg <= prev_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame.valid && frame.ready) begin
            s1_payload_reg <= frame.payload;
            s1_len_reg     <= frame.frame_length;
        end
        if (s1_adv) begin
            status_reg  <= status_next;
            rx_reg      <= rx_next;
            crc_reg     <= crc_next;
            seq_reg     <= seq_next;
            speed_reg   <= speed_next;
            rpm_reg     <= rpm_next;
            coolant_reg <= coolant_next;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.status         = status_reg;
    assign result.received_check = rx_reg;
    assign result.computed_check = crc_reg;
    assign result.sequence_count = seq_reg;
    assign result.speed          = speed_reg;
    assign result.engine_speed   = rpm_reg;
    assign result.coolant        = coolant_reg;

    `E2ECAN_ASSERT_NOW(a_accept_crc_match, clk, rst_n,
        out_valid_reg && status_reg == ST_ACCEPTED, rx_reg == crc_reg,
        "accepted result with mismatching CRC")
    `E2ECAN_ASSERT_NOW(a_short_zeroed, clk, rst_n,
        out_valid_reg && status_reg == ST_SHORT,
        rx_reg == '0 && crc_reg == '0 && seq_reg == '0 && speed_reg == '0,
        "short frame result carries nonzero fields")
    `E2ECAN_ASSERT_NEXT(a_counter_update, clk, rst_n, s1_adv && s1_accept,
        have_prev_reg && prev_count_reg == $past(cnt),
        "rolling counter not updated on acceptance")
    `E2ECAN_ASSERT_NOW(a_cnt_err_needs_prev, clk, rst_n,
        out_valid_reg && status_reg == ST_CNT_ERR, have_prev_reg,
        "counter mismatch reported before any accepted frame")
    `E2ECAN_ASSERT_NEXT(a_hold_on_stall, clk, rst_n,
        out_valid_reg && !result.ready, out_valid_reg && $stable(status_reg),
        "result dropped or changed while stalled")

endmodule
